[src/hts_pkg.sv]
// Shared types and constants of the hybrid tick task scheduler.
// Holds the entry layout, command and event codes, and FSM states.
// No dependencies.
`default_nettype none

package hts_pkg;

    // Default table depth and the cap on result beats per command.
    localparam int NUM_TASKS_DEF = 16;
    localparam int MAX_RES       = 16;

    // Command codes carried in the func field.
    typedef enum logic [2:0] {
        FUNC_TICK     = 3'd0,
        FUNC_DISPATCH = 3'd1,
        FUNC_ADD      = 3'd2,
        FUNC_DELETE   = 3'd3,
        FUNC_ENABLE   = 3'd4,
        FUNC_DISABLE  = 3'd5
    } func_t;

    // Event codes carried in the event_res field.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_COOP  = 3'd1,
        EV_PRE   = 3'd2,
        EV_ADDED = 3'd3,
        EV_FULL  = 3'd4,
        EV_DONE  = 3'd5
    } ev_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SINGLE,
        ST_FINISH
    } state_t;

    // One task table entry as stored in the memory.
    typedef struct packed {
        logic [31:0] countdown;
        logic [31:0] period;
        logic [7:0]  pending;
        logic        coop;
        logic        enabled;
        logic        job;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        countdown: 32'd0,
        period:    32'd0,
        pending:   8'd0,
        coop:      1'b1,
        enabled:   1'b0,
        job:       1'b0
    };

endpackage

`default_nettype wire

[src/hybrid_tick_task_scheduler_unit.sv]
// Top level of the hybrid tick task scheduler: task table memory and sequencer.
// Depends on hts_pkg.
// Sequencing: tick and dispatch walk the table in ST_WALK, then ST_FINISH loads the final result
//   beat into the output register; other commands pass through ST_SINGLE and then ST_FINISH.
// Throughput: one command at a time; a tick or dispatch walks one table entry per cycle unless
//   a displaced report is held up by output back-pressure, which stalls the walk.
// Reset: per-entry valid bits clear at once, so every entry reads as its reset value.
`default_nettype none

module hybrid_tick_task_scheduler_unit #(
    parameter int NUM_TASKS = hts_pkg::NUM_TASKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0 up: func[2:0], task_slot[6:3], has_job[7],
    // first_delay[39:8], period[71:40], coop[72], start_enabled[73], zero pad
    input  wire logic [79:0] s_axis_tdata,
    // Result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0 up: event_res[2:0], slot[6:3], zero pad[7]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);

    // Table index width and the width of the free-slot counter, which must
    // reach NUM_TASKS itself.
    localparam int IW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int NFW = $clog2(NUM_TASKS + 1);
    localparam int NW  = $clog2(hts_pkg::MAX_RES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TASKS - 1);

    // ------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------
    logic [2:0]     in_func;
    logic [3:0]     in_slot;
    hts_pkg::entry_t in_entry;

    assign in_func  = s_axis_tdata[2:0];
    assign in_slot  = s_axis_tdata[6:3];
    assign in_entry = '{
        countdown: s_axis_tdata[39:8],
        period:    s_axis_tdata[71:40],
        pending:   8'd0,
        coop:      s_axis_tdata[72],
        enabled:   s_axis_tdata[73],
        job:       s_axis_tdata[7]
    };

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    hts_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [NFW-1:0]  next_free_reg, next_free_next;

    logic [2:0]      func_reg;
    logic [3:0]      ts_reg;
    hts_pkg::entry_t add_reg;

    // Held result: the latest report of a command, released as the final
    // beat once the command is complete, or as a non-final beat when a
    // newer report displaces it.
    logic            held_valid_reg, held_valid_next;
    hts_pkg::ev_t    held_ev_reg, held_ev_next;
    logic [3:0]      held_slot_reg, held_slot_next;

    logic            out_valid_reg, out_valid_next;
    hts_pkg::ev_t    out_ev_reg, out_ev_next;
    logic [3:0]      out_slot_reg, out_slot_next;
    logic            out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // Task table memory: one write port, one registered read port.
    // Accesses never overlap on one entry: a walk writes entry k back while
    // it reads k + 1, and single-entry commands read in the accept cycle and
    // write in the next one, with the next command accepted only later.
    // ------------------------------------------------------------------
    hts_pkg::entry_t table_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] entry_valid_reg;
    hts_pkg::entry_t rd_data_reg;
    logic            rd_valid_reg;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    hts_pkg::entry_t mem_wdata;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                entry_valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_valid_reg <= entry_valid_reg[mem_raddr];
            end
        end
    end

    // An entry never written reads as its reset value.
    hts_pkg::entry_t cur;
    assign cur = rd_valid_reg ? rd_data_reg : hts_pkg::ENTRY_RESET;

    // ------------------------------------------------------------------
    // Walk datapath: update one entry for tick or dispatch
    // ------------------------------------------------------------------
    hts_pkg::entry_t walk_upd;
    logic            walk_rep;
    hts_pkg::ev_t    walk_ev;

    always_comb
    begin
        walk_upd = cur;
        walk_rep = 1'b0;
        walk_ev  = hts_pkg::EV_NONE;
        if (func_reg == hts_pkg::FUNC_TICK)
        begin
            walk_ev = hts_pkg::EV_PRE;
            if (cur.enabled)
            begin
                if (cur.countdown == 32'd0)
                begin
                    // Expired: a cooperative entry queues a run, a
                    // preemptive one with a job reports now.
                    if (cur.coop)
                    begin
                        if (cur.pending != 8'hFF)
                        begin
                            walk_upd.pending = cur.pending + 8'd1;
                        end
                    end
                    else
                    begin
                        walk_rep = cur.job;
                    end
                    // One-shot entries stay at zero and fire every tick.
                    if (cur.period != 32'd0)
                    begin
                        walk_upd.countdown = cur.period;
                    end
                end
                else
                begin
                    walk_upd.countdown = cur.countdown - 32'd1;
                end
            end
        end
        else
        begin
            walk_ev = hts_pkg::EV_COOP;
            if (cur.coop && (cur.pending != 8'd0))
            begin
                walk_rep         = cur.job;
                walk_upd.pending = cur.pending - 8'd1;
            end
            if (cur.period == 32'd0)
            begin
                walk_upd.job = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_free;
    logic rep_keep;
    logic rep_push;
    logic advance;
    logic ts_ok;
    logic nf_ok;

    assign out_free = !out_valid_reg || m_axis_tready;
    // Reports past the per-command cap are dropped; the table still updates.
    assign rep_keep = walk_rep && (n_reg < NW'(hts_pkg::MAX_RES));
    assign rep_push = rep_keep && held_valid_reg;
    // Stall the walk while a displaced report cannot reach the output.
    assign advance  = !rep_push || out_free;
    assign ts_ok    = 32'(ts_reg) < NUM_TASKS;
    assign nf_ok    = 32'(next_free_reg) < NUM_TASKS;

    assign s_axis_tready = (state_reg == hts_pkg::ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        next_free_next  = next_free_reg;
        held_valid_next = held_valid_reg;
        held_ev_next    = held_ev_reg;
        held_slot_next  = held_slot_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_ev_next     = out_ev_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = walk_upd;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            hts_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mem_re          = 1'b1;
                    idx_next        = '0;
                    n_next          = '0;
                    held_valid_next = 1'b0;
                    if (in_func inside {hts_pkg::FUNC_TICK, hts_pkg::FUNC_DISPATCH})
                    begin
                        mem_raddr  = '0;
                        state_next = hts_pkg::ST_WALK;
                    end
                    else
                    begin
                        mem_raddr  = IW'(in_slot);
                        state_next = hts_pkg::ST_SINGLE;
                    end
                end
            end

            hts_pkg::ST_WALK:
            begin
                if (advance)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = walk_upd;
                    if (rep_keep)
                    begin
                        held_valid_next = 1'b1;
                        held_ev_next    = walk_ev;
                        held_slot_next  = 4'(idx_reg);
                        n_next          = n_reg + NW'(1);
                    end
                    if (rep_push)
                    begin
                        out_valid_next = 1'b1;
                        out_ev_next    = held_ev_reg;
                        out_slot_next  = held_slot_reg;
                        out_last_next  = 1'b0;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = hts_pkg::ST_FINISH;
                    end
                    else
                    begin
                        idx_next  = idx_reg + IW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + IW'(1);
                    end
                end
            end

            hts_pkg::ST_SINGLE:
            begin
                state_next = hts_pkg::ST_FINISH;
                mem_waddr  = IW'(ts_reg);
                mem_wdata  = cur;
                case (func_reg)
                    hts_pkg::FUNC_ADD:
                    begin
                        held_valid_next = 1'b1;
                        if (nf_ok)
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = IW'(next_free_reg);
                            mem_wdata      = add_reg;
                            next_free_next = next_free_reg + NFW'(1);
                            held_ev_next   = hts_pkg::EV_ADDED;
                            held_slot_next = 4'(next_free_reg);
                        end
                        else
                        begin
                            held_ev_next   = hts_pkg::EV_FULL;
                            held_slot_next = 4'd0;
                        end
                    end
                    hts_pkg::FUNC_DELETE:
                    begin
                        // Clear the entry but keep its mode bit.
                        mem_we            = ts_ok;
                        mem_wdata         = hts_pkg::ENTRY_RESET;
                        mem_wdata.coop    = cur.coop;
                        held_valid_next   = 1'b1;
                        held_ev_next      = hts_pkg::EV_DONE;
                        held_slot_next    = ts_reg;
                    end
                    hts_pkg::FUNC_ENABLE:
                    begin
                        mem_we              = ts_ok;
                        mem_wdata.enabled   = 1'b1;
                        mem_wdata.countdown = cur.period;
                        held_valid_next     = 1'b1;
                        held_ev_next        = hts_pkg::EV_DONE;
                        held_slot_next      = ts_reg;
                    end
                    hts_pkg::FUNC_DISABLE:
                    begin
                        mem_we            = ts_ok;
                        mem_wdata.enabled = 1'b0;
                        held_valid_next   = 1'b1;
                        held_ev_next      = hts_pkg::EV_DONE;
                        held_slot_next    = ts_reg;
                    end
                    default:
                    begin
                        // Unknown command: no edit, finish reports nothing.
                        held_valid_next = 1'b0;
                    end
                endcase
            end

            hts_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_ev_next     = held_valid_reg ? held_ev_reg : hts_pkg::EV_NONE;
                    out_slot_next   = held_valid_reg ? held_slot_reg : 4'd0;
                    held_valid_next = 1'b0;
                    state_next      = hts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hts_pkg::ST_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            next_free_reg  <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            next_free_reg  <= next_free_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg <= in_func;
            ts_reg   <= in_slot;
            add_reg  <= in_entry;
        end
        held_ev_reg   <= held_ev_next;
        held_slot_reg <= held_slot_next;
        out_ev_reg    <= out_ev_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_slot_reg, out_ev_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[src/hts_checker.sv]
// Port-level checker of the hybrid tick task scheduler and its bind.
// Depends on hts_pkg and hybrid_tick_task_scheduler_unit.
`default_nettype none

module hts_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // One command at a time: an accepted beat closes the command channel.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while busy");

    // While ready for a command, any waiting result is a final beat.
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("non-final result pending while idle");

    // Only run reports may be non-final.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != hts_pkg::EV_COOP)
            && (m_axis_tdata[2:0] != hts_pkg::EV_PRE) |-> m_axis_tlast)
        else $error("status result not marked last");

    // Event codes stay in range and the pad bit is zero.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= hts_pkg::EV_DONE) && !m_axis_tdata[7])
        else $error("bad result encoding");

endmodule

bind hybrid_tick_task_scheduler_unit hts_checker u_hts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for hybrid_tick_task_scheduler_unit: command beats in, result beats out.
// Holds its own task-table predictor and a directed table followed by random phases.
// Depends on hts_pkg and the scheduler top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TASKS   = hts_pkg::NUM_TASKS_DEF;
    localparam int STALL_LIMIT = 4000;

    // Command codes with no action in the block.
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    // Entry kept alive through the random phases so its run count can saturate.
    localparam logic [3:0] SAT_SLOT = 4'd4;

    typedef enum {MIX_EDIT, MIX_TICKS, MIX_DRAIN} mix_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  task_slot;
        logic        has_job;
        logic [31:0] first_delay;
        logic [31:0] period;
        logic        coop;
        logic        start_enabled;
    } sched_cmd_t;

    typedef struct packed {
        hts_pkg::ev_t ev;
        logic [3:0]   slot;
        logic         last;
    } sched_result_t;

    typedef struct packed {
        sched_cmd_t    cmd;
        logic          fixed;
        sched_result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    // Predicted task table.
    logic [31:0] ticks_left [NUM_TASKS];
    logic [31:0] reload_val [NUM_TASKS];
    logic [7:0]  runs_owed  [NUM_TASKS];
    logic        coop_mode  [NUM_TASKS];
    logic        armed      [NUM_TASKS];
    logic        has_work   [NUM_TASKS];
    logic [4:0]  fill_ptr;

    sched_result_t step_beats[$];
    sched_result_t expected_beats[$];
    dir_row_t      directed[$];

    int err_count = 0;
    int cmds_sent = 0;
    int beats_seen = 0;
    int coop_runs = 0;
    int pre_runs = 0;
    int full_seen = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit saturated = 1'b0;

    int         stall_left = 0;
    int         stall_mode = 0;
    logic [7:0] ready_pat = 8'b1011_0010;

    hybrid_tick_task_scheduler_unit #(
        .NUM_TASKS(NUM_TASKS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Queue one run report, dropping reports past the per-command cap.
    function automatic void note_run(input hts_pkg::ev_t e, input logic [3:0] s);
        sched_result_t r;
        r.ev = e;
        r.slot = s;
        r.last = 1'b0;
        if (step_beats.size() < hts_pkg::MAX_RES)
            step_beats.push_back(r);
    endfunction

    // Apply one command to the predicted table and collect its result beats.
    task automatic predict_schedule(input sched_cmd_t c);
        int i;
        int s;
        step_beats = {};
        s = int'(c.task_slot);
        case (c.func)
            hts_pkg::FUNC_TICK:
                for (i = 0; i < NUM_TASKS; i++)
                begin
                    if (armed[i])
                    begin
                        if (ticks_left[i] == 32'd0)
                        begin
                            if (coop_mode[i])
                            begin
                                if (runs_owed[i] != 8'hFF)
                                    runs_owed[i]++;
                                else
                                    saturated = 1'b1;
                            end
                            else if (has_work[i])
                                note_run(hts_pkg::EV_PRE, 4'(i));
                            if (reload_val[i] != 32'd0)
                                ticks_left[i] = reload_val[i];
                        end
                        else
                            ticks_left[i]--;
                    end
                end
            hts_pkg::FUNC_DISPATCH:
                for (i = 0; i < NUM_TASKS; i++)
                begin
                    if (coop_mode[i] && runs_owed[i] != 8'd0)
                    begin
                        if (has_work[i])
                            note_run(hts_pkg::EV_COOP, 4'(i));
                        runs_owed[i]--;
                    end
                    // one-shot entries lose their job after every dispatch
                    if (reload_val[i] == 32'd0)
                        has_work[i] = 1'b0;
                end
            hts_pkg::FUNC_ADD:
                if (fill_ptr < NUM_TASKS)
                begin
                    has_work[fill_ptr]   = c.has_job;
                    ticks_left[fill_ptr] = c.first_delay;
                    reload_val[fill_ptr] = c.period;
                    runs_owed[fill_ptr]  = 8'd0;
                    coop_mode[fill_ptr]  = c.coop;
                    armed[fill_ptr]      = c.start_enabled;
                    note_run(hts_pkg::EV_ADDED, fill_ptr[3:0]);
                    fill_ptr++;
                end
                else
                    note_run(hts_pkg::EV_FULL, 4'd0);
            hts_pkg::FUNC_DELETE:
            begin
                if (s < NUM_TASKS)
                begin
                    has_work[s]   = 1'b0;
                    ticks_left[s] = 32'd0;
                    reload_val[s] = 32'd0;
                    runs_owed[s]  = 8'd0;
                    armed[s]      = 1'b0;
                end
                note_run(hts_pkg::EV_DONE, c.task_slot);
            end
            hts_pkg::FUNC_ENABLE:
            begin
                if (s < NUM_TASKS)
                begin
                    armed[s] = 1'b1;
                    ticks_left[s] = reload_val[s];
                end
                note_run(hts_pkg::EV_DONE, c.task_slot);
            end
            hts_pkg::FUNC_DISABLE:
            begin
                if (s < NUM_TASKS)
                    armed[s] = 1'b0;
                note_run(hts_pkg::EV_DONE, c.task_slot);
            end
            default: ;
        endcase
        if (step_beats.size() == 0)
            note_run(hts_pkg::EV_NONE, 4'd0);
    endtask

    function automatic dir_row_t mk_row(input logic [2:0] f, input logic [3:0] ts,
                                        input logic job, input logic [31:0] dly,
                                        input logic [31:0] per, input logic cp,
                                        input logic en, input logic fixed,
                                        input hts_pkg::ev_t e, input logic [3:0] rs);
        dir_row_t r;
        r.cmd.func = f;
        r.cmd.task_slot = ts;
        r.cmd.has_job = job;
        r.cmd.first_delay = dly;
        r.cmd.period = per;
        r.cmd.coop = cp;
        r.cmd.start_enabled = en;
        r.fixed = fixed;
        r.want.ev = e;
        r.want.slot = rs;
        r.want.last = 1'b1;
        return r;
    endfunction

    // Draw one command; every field is random, the mix sets the command spread.
    function automatic sched_cmd_t random_cmd(input mix_t mix);
        sched_cmd_t c;
        int pick;
        c.func = hts_pkg::FUNC_TICK;
        c.task_slot = 4'($urandom_range(0, 15));
        c.has_job = 1'($urandom_range(0, 1));
        c.first_delay = $urandom;
        c.period = $urandom;
        c.coop = 1'($urandom_range(0, 1));
        c.start_enabled = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_EDIT:
            begin
                if (pick < 25)
                begin
                    c.func = hts_pkg::FUNC_ADD;
                    // short timing on most adds so entries actually fire
                    if ($urandom_range(0, 5) != 0)
                    begin
                        c.first_delay = $urandom_range(0, 4);
                        c.period = $urandom_range(0, 5);
                    end
                end
                else if (pick < 45)
                    c.func = hts_pkg::FUNC_TICK;
                else if (pick < 65)
                    c.func = hts_pkg::FUNC_DISPATCH;
                else if (pick < 73)
                    c.func = hts_pkg::FUNC_DELETE;
                else if (pick < 83)
                    c.func = hts_pkg::FUNC_ENABLE;
                else if (pick < 95)
                    c.func = hts_pkg::FUNC_DISABLE;
                else
                    c.func = (pick % 2 == 0) ? FUNC_RSVD6 : FUNC_RSVD7;
                if ((c.func == hts_pkg::FUNC_DELETE || c.func == hts_pkg::FUNC_DISABLE)
                    && c.task_slot == SAT_SLOT)
                    c.task_slot = SAT_SLOT + 4'd1;
            end
            MIX_TICKS:
            begin
                if (pick < 94)
                    c.func = hts_pkg::FUNC_TICK;
                else
                begin
                    c.func = hts_pkg::FUNC_ENABLE;
                    if (c.task_slot == SAT_SLOT)
                        c.task_slot = SAT_SLOT + 4'd1;
                end
            end
            default:
                c.func = (pick < 85) ? hts_pkg::FUNC_DISPATCH : hts_pkg::FUNC_TICK;
        endcase
        return c;
    endfunction

    // Drive one command beat at the falling edge, hold it until accepted,
    // then predict its results.
    task automatic send_cmd(input sched_cmd_t c, input logic fixed,
                            input sched_result_t want);
        int gap;
        int k;
        sched_result_t r;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tdata = {6'b0, c.start_enabled, c.coop, c.period, c.first_delay,
                        c.has_job, c.task_slot, c.func};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        cmds_sent++;
        predict_schedule(c);
        if (fixed)
            expected_beats.push_back(want);
        else
            for (k = 0; k < step_beats.size(); k++)
            begin
                r = step_beats[k];
                r.last = (k == step_beats.size() - 1);
                expected_beats.push_back(r);
            end
    endtask

    // Hold the command channel idle until every predicted beat has come out.
    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0)
            @(negedge clk);
    endtask

    // Result-side back-pressure: switch between stall styles every so often.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        else
            stall_left--;
        case (stall_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = 1'($urandom_range(0, 1));
            2: m_axis_tready = ($urandom_range(0, 3) == 0);
            default:
            begin
                ready_pat = {ready_pat[6:0], ready_pat[7]};
                m_axis_tready = ready_pat[0];
            end
        endcase
    end

    // Check each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        sched_result_t want;
        hts_pkg::ev_t got_ev;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            got_ev = hts_pkg::ev_t'(m_axis_tdata[2:0]);
            if (got_ev == hts_pkg::EV_COOP)
                coop_runs++;
            if (got_ev == hts_pkg::EV_PRE)
                pre_runs++;
            if (got_ev == hts_pkg::EV_FULL)
                full_seen++;
            if (expected_beats.size() == 0)
                report_mismatch($sformatf("result beat with nothing expected: ev=%0d slot=%0d",
                                          m_axis_tdata[2:0], m_axis_tdata[6:3]));
            else
            begin
                want = expected_beats.pop_front();
                if (m_axis_tdata[2:0] !== want.ev)
                    report_mismatch($sformatf("event_res %0d, expected %0d (slot %0d)",
                                              m_axis_tdata[2:0], want.ev, want.slot));
                if (m_axis_tdata[6:3] !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d (event %0d)",
                                              m_axis_tdata[6:3], want.slot, want.ev));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, expected %0b (event %0d slot %0d)",
                                              m_axis_tlast, want.last, want.ev, want.slot));
            end
        end
    end

    // Abort when neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, expected_beats.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        sched_result_t none;
        none = '0;

        for (i = 0; i < NUM_TASKS; i++)
        begin
            ticks_left[i] = 32'd0;
            reload_val[i] = 32'd0;
            runs_owed[i]  = 8'd0;
            coop_mode[i]  = 1'b1;
            armed[i]      = 1'b0;
            has_work[i]   = 1'b0;
        end
        fill_ptr = 5'd0;

        // Empty table, reserved codes and edits, then adds covering one-shot,
        // extreme timing, preemptive and the one-shot entry that later saturates.
        directed.push_back(mk_row(hts_pkg::FUNC_TICK, 4'd0, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_DISPATCH, 4'd0, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(FUNC_RSVD6, 4'd15, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
                                  1, hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(FUNC_RSVD7, 4'd0, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_DELETE, 4'd15, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_DONE, 4'd15));
        directed.push_back(mk_row(hts_pkg::FUNC_ENABLE, 4'd9, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_DONE, 4'd9));
        directed.push_back(mk_row(hts_pkg::FUNC_DISABLE, 4'd0, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_DONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_ADD, 4'd0, 1, 32'd0, 32'd0, 1, 1, 1,
                                  hts_pkg::EV_ADDED, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_ADD, 4'd0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  0, 1, 1, hts_pkg::EV_ADDED, 4'd1));
        directed.push_back(mk_row(hts_pkg::FUNC_ADD, 4'd0, 1, 32'd0, 32'd1, 0, 1, 1,
                                  hts_pkg::EV_ADDED, 4'd2));
        directed.push_back(mk_row(hts_pkg::FUNC_ADD, 4'd0, 0, 32'd1, 32'd2, 1, 1, 1,
                                  hts_pkg::EV_ADDED, 4'd3));
        directed.push_back(mk_row(hts_pkg::FUNC_ADD, 4'd0, 1, 32'd2, 32'd0, 1, 0, 1,
                                  hts_pkg::EV_ADDED, 4'd4));
        directed.push_back(mk_row(hts_pkg::FUNC_ADD, 4'd0, 1, 32'd0, 32'd0, 0, 1, 1,
                                  hts_pkg::EV_ADDED, 4'd5));
        directed.push_back(mk_row(hts_pkg::FUNC_TICK, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_TICK, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_DISPATCH, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_ENABLE, 4'd4, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_DONE, 4'd4));
        directed.push_back(mk_row(hts_pkg::FUNC_TICK, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_TICK, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_DISPATCH, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_DISABLE, 4'd2, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_DONE, 4'd2));
        directed.push_back(mk_row(hts_pkg::FUNC_TICK, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_DELETE, 4'd3, 0, 32'd0, 32'd0, 0, 0, 1,
                                  hts_pkg::EV_DONE, 4'd3));
        directed.push_back(mk_row(hts_pkg::FUNC_DISPATCH, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));
        directed.push_back(mk_row(hts_pkg::FUNC_TICK, 4'd0, 0, 32'd0, 32'd0, 0, 0, 0,
                                  hts_pkg::EV_NONE, 4'd0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[k])
            send_cmd(directed[k].cmd, directed[k].fixed, directed[k].want);
        hold_until_drained();

        // Mixed edits: fills the table, then keeps adding into a full one.
        repeat (60) send_cmd(random_cmd(MIX_EDIT), 1'b0, none);
        hold_until_drained();

        // Long tick run with no dispatch drives the kept entry's run count
        // into saturation; it fires on every tick.
        repeat (290) send_cmd(random_cmd(MIX_TICKS), 1'b0, none);
        hold_until_drained();

        // Dispatch-heavy tail works the owed runs back down.
        repeat (30) send_cmd(random_cmd(MIX_DRAIN), 1'b0, none);
        hold_until_drained();

        // Catch any stray beat after the last expected one.
        repeat (NUM_TASKS + 8) @(negedge clk);

        $display("run: %0d commands, %0d result beats (%0d cooperative runs, %0d preemptive runs,",
                 cmds_sent, beats_seen, coop_runs, pre_runs);
        $display("     %0d table-full replies), run counter saturation reached: %0s, %0d mismatches",
                 full_seen, saturated ? "yes" : "no", err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
src/hts_pkg.sv
src/hybrid_tick_task_scheduler_unit.sv
src/hts_checker.sv
tb/tb.sv
